>>> rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error(msg);

`endif

>>> rtl/tlbpt_pkg.sv
// Shared constants, types and helper functions of the TLB page-table translator.
package tlbpt_pkg;

    localparam int TLB_ENTRIES = 16;
    localparam int PAGE_COUNT  = 256;
    localparam int PAGE_BYTES  = 256;

    localparam int VA_W      = 16;
    localparam int PA_W      = 16;
    localparam int OFFSET_W  = $clog2(PAGE_BYTES);
    localparam int PAGE_W    = $clog2(PAGE_COUNT);
    localparam int FRAME_W   = PAGE_W;
    localparam int NFF_W     = PAGE_W + 1;
    localparam int TLB_IDX_W = $clog2(TLB_ENTRIES);
    localparam int TLB_CNT_W = $clog2(TLB_ENTRIES + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [TLB_CNT_W-1:0] TLB_FULL = TLB_CNT_W'(TLB_ENTRIES);
    localparam logic [NFF_W-1:0]     NFF_MAX  = NFF_W'(PAGE_COUNT);

    typedef logic [PAGE_W-1:0]   page_t;
    typedef logic [OFFSET_W-1:0] offset_t;
    typedef logic [FRAME_W-1:0]  frame_t;

    // Classified request handed from the front to the back
    typedef struct packed {
        page_t   page;
        offset_t offset;
        logic    hit;
        frame_t  frame;
    } q_item_t;

    // New page/frame pair for the TLB, sent back to the front
    typedef struct packed {
        logic   valid;
        page_t  page;
        frame_t frame;
    } tlb_upd_t;

    function automatic page_t page_of(input logic [VA_W-1:0] va);
        logic [VA_W-1:0] sh;
        sh = va >> OFFSET_W;
        return page_t'(sh);
    endfunction

    function automatic offset_t offset_of(input logic [VA_W-1:0] va);
        return offset_t'(va);
    endfunction

    function automatic logic [PA_W-1:0] phys_addr(input frame_t frame, input offset_t offset);
        logic [FRAME_W+OFFSET_W-1:0] full;
        full = {frame, offset};
        return PA_W'(full);
    endfunction

endpackage

>>> rtl/tlbpt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tlbpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/tlbpt_queue.sv
// Short request queue between the lookup front and the page-table back.
module tlbpt_queue import tlbpt_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  q_item_t           push_item,
    output logic              ready,
    input  logic              pop,
    output logic              valid,
    output q_item_t           head,
    output logic [QCNT_W-1:0] count
);

    q_item_t           mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);

    assign ready   = (count_reg != CNT_FULL);
    assign valid   = (count_reg != '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign count   = count_reg;
    assign do_push = push && ready;
    assign do_pop  = pop && valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/tlbpt_front.sv
// Front end: accepts addresses, searches the TLB and keeps its FIFO replacement state.
module tlbpt_front import tlbpt_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [VA_W-1:0] s_va,
    output logic            q_push,
    output q_item_t         q_item,
    input  logic            q_ready,
    input  tlb_upd_t        tlb_upd,
    output logic            miss_pending
);

    page_t                 tag_reg [TLB_ENTRIES];
    frame_t                frm_reg [TLB_ENTRIES];
    logic [TLB_CNT_W-1:0]  fill_reg, fill_next;
    logic [TLB_IDX_W-1:0]  oldest_reg, oldest_next;
    logic                  miss_pend_reg, miss_pend_next;

    page_t                 page;
    logic                  hit;
    frame_t                hit_frame;
    logic                  accept;
    logic                  tlb_full;
    logic [TLB_IDX_W-1:0]  ins_slot;

    localparam logic [TLB_IDX_W-1:0] SLOT_LAST = TLB_IDX_W'(TLB_ENTRIES - 1);

    assign page = page_of(s_va);

    // Scan valid slots; lowest matching slot wins
    always_comb begin
        hit       = 1'b0;
        hit_frame = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
            if ((TLB_CNT_W'(i) < fill_reg) && (tag_reg[i] == page)) begin
                hit       = 1'b1;
                hit_frame = frm_reg[i];
            end
        end
    end

    // Hold new requests while a miss may still change the TLB
    assign s_tready = q_ready && !miss_pend_reg;
    assign accept   = s_tvalid && s_tready;

    assign q_push        = accept;
    assign q_item.page   = page;
    assign q_item.offset = offset_of(s_va);
    assign q_item.hit    = hit;
    assign q_item.frame  = hit_frame;

    assign miss_pending = miss_pend_reg;

    assign tlb_full = (fill_reg == TLB_FULL);
    assign ins_slot = tlb_full ? oldest_reg : fill_reg[TLB_IDX_W-1:0];

    always_comb begin
        fill_next      = fill_reg;
        oldest_next    = oldest_reg;
        miss_pend_next = miss_pend_reg;
        if (accept && !hit) begin
            miss_pend_next = 1'b1;
        end else if (tlb_upd.valid) begin
            miss_pend_next = 1'b0;
        end
        if (tlb_upd.valid) begin
            if (!tlb_full) begin
                fill_next = fill_reg + 1'b1;
            end else begin
                oldest_next = (oldest_reg == SLOT_LAST) ? '0 : oldest_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (tlb_upd.valid) begin
            tag_reg[ins_slot] <= tlb_upd.page;
            frm_reg[ins_slot] <= tlb_upd.frame;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            oldest_reg    <= '0;
            miss_pend_reg <= 1'b0;
        end else begin
            fill_reg      <= fill_next;
            oldest_reg    <= oldest_next;
            miss_pend_reg <= miss_pend_next;
        end
    end

endmodule

>>> rtl/tlbpt_back.sv
// Back end: resolves TLB misses in the page table, assigns frames and drives the result.
module tlbpt_back import tlbpt_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    input  q_item_t         q_item,
    output logic            q_pop,
    output tlb_upd_t        tlb_upd,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [PA_W-1:0] m_pa,
    output logic            m_hit,
    output logic            m_fault
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic                  state_reg, state_next;
    page_t                 hold_page_reg;
    offset_t               hold_off_reg;
    logic [PAGE_COUNT-1:0] present_reg;
    logic [NFF_W-1:0]      nff_reg, nff_next;
    logic                  m_valid_reg, m_valid_next;
    logic [PA_W-1:0]       m_pa_reg;
    logic                  m_hit_reg;
    logic                  m_fault_reg;

    logic                  out_free;
    logic                  out_load;
    logic [PA_W-1:0]       out_pa;
    logic                  out_hit;
    logic                  out_fault;
    logic                  set_present;
    logic                  ram_we;
    page_t                 ram_raddr;
    frame_t                ram_rdata;
    frame_t                new_frame;

    assign out_free  = !m_valid_reg || m_tready;
    assign new_frame = nff_reg[FRAME_W-1:0];
    // Keep the read address on the held page so the read data stays put
    assign ram_raddr = (state_reg == ST_IDLE) ? q_item.page : hold_page_reg;

    tlbpt_ram #(
        .WIDTH(FRAME_W),
        .DEPTH(PAGE_COUNT)
    ) u_page_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (q_item.page),
        .wdata (new_frame),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        q_pop         = 1'b0;
        tlb_upd       = '0;
        out_load      = 1'b0;
        out_pa        = '0;
        out_hit       = 1'b0;
        out_fault     = 1'b0;
        set_present   = 1'b0;
        ram_we        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop = 1'b1;
                    if (q_item.hit) begin
                        out_load = 1'b1;
                        out_pa   = phys_addr(q_item.frame, q_item.offset);
                        out_hit  = 1'b1;
                    end else if (!present_reg[q_item.page]) begin
                        // Page fault: hand out the next free frame
                        ram_we        = 1'b1;
                        set_present   = 1'b1;
                        out_load      = 1'b1;
                        out_pa        = phys_addr(new_frame, q_item.offset);
                        out_fault     = 1'b1;
                        tlb_upd.valid = 1'b1;
                        tlb_upd.page  = q_item.page;
                        tlb_upd.frame = new_frame;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    out_pa        = phys_addr(ram_rdata, hold_off_reg);
                    tlb_upd.valid = 1'b1;
                    tlb_upd.page  = hold_page_reg;
                    tlb_upd.frame = ram_rdata;
                    state_next    = ST_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        nff_next = nff_reg;
        if (set_present && (nff_reg < NFF_MAX)) begin
            nff_next = nff_reg + 1'b1;
        end
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            hold_page_reg <= q_item.page;
            hold_off_reg  <= q_item.offset;
        end
        if (out_load) begin
            m_pa_reg    <= out_pa;
            m_hit_reg   <= out_hit;
            m_fault_reg <= out_fault;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            present_reg <= '0;
            nff_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            nff_reg     <= nff_next;
            m_valid_reg <= m_valid_next;
            if (set_present) begin
                present_reg[q_item.page] <= 1'b1;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_pa     = m_pa_reg;
    assign m_hit    = m_hit_reg;
    assign m_fault  = m_fault_reg;

endmodule

>>> rtl/tlb_page_table_translator_core.sv
// Top level of the TLB page-table translator: front, request queue and back joined.
// Translates each 16-bit virtual address (page in the upper byte, offset in the lower) into a
// physical address, giving one result per request with TLB-hit and page-fault flags. A TLB hit
// is classified by the 16-entry parallel tag compare and then flows through the two-entry queue
// at one request per cycle while results are taken and no miss is pending. A miss holds the
// input until the back has updated the TLB: a page fault gets its frame in the back's idle
// state; a present-page miss waits in the read state for a registered 256-entry page map read.
// The output register reloads in the cycle its result is taken; while a result waits, the back
// holds and the queue absorbs up to two more requests before the input stalls.
// No clearing pass is needed after reset; the block takes requests once reset is released.
`include "assert_macros.svh"

module tlb_page_table_translator_core import tlbpt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] virtual_address
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] physical_address
    output logic [1:0]  m_tuser    // [0] tlb_hit, [1] page_fault
);

    logic              q_push;
    q_item_t           q_in_item;
    logic              q_ready;
    logic              q_pop;
    logic              q_valid;
    q_item_t           q_head;
    logic [QCNT_W-1:0] q_count;
    tlb_upd_t          tlb_upd;
    logic              miss_pending;
    logic [PA_W-1:0]   m_pa;
    logic              m_hit;
    logic              m_fault;

    tlbpt_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_va         (s_tdata),
        .q_push       (q_push),
        .q_item       (q_in_item),
        .q_ready      (q_ready),
        .tlb_upd      (tlb_upd),
        .miss_pending (miss_pending)
    );

    tlbpt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in_item),
        .ready     (q_ready),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head),
        .count     (q_count)
    );

    tlbpt_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_head),
        .q_pop    (q_pop),
        .tlb_upd  (tlb_upd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_pa     (m_pa),
        .m_hit    (m_hit),
        .m_fault  (m_fault)
    );

    assign m_tdata = m_pa;
    assign m_tuser = {m_fault, m_hit};

    `ASSERT_NEVER(a_flags_exclusive, m_tvalid && m_tuser[0] && m_tuser[1], "hit and fault both set")
    `ASSERT_CLK(a_upd_needs_miss, tlb_upd.valid |-> miss_pending, "TLB update without a miss")
    `ASSERT_CLK(a_queue_bound, q_count <= QCNT_W'(QUEUE_DEPTH), "request queue overfilled")
    `ASSERT_NEVER(a_pop_on_empty, q_pop && !q_valid, "pop from empty request queue")

endmodule

>>> bench/tb_tlb_page_table_translator_core.sv
// Testbench for the TLB page-table translator: directed and random address streams.
module tb_tlb_page_table_translator_core import tlbpt_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT   = 1000;
    localparam int RANDOM_ITEMS  = 900;
    localparam int RECENT_DEPTH  = 24;
    localparam int TAIL_CYCLES   = 20;
    localparam int MAX_PRINTED   = 30;

    typedef struct packed {
        logic [PA_W-1:0] phys;
        logic            hit;
        logic            fault;
    } xlat_result_t;

    // Mirror of the TLB and page table; holds the translations still in flight
    class xlat_scoreboard;
        page_t        tlb_tag [TLB_ENTRIES];
        frame_t       tlb_frame [TLB_ENTRIES];
        int unsigned  tlb_used;
        int unsigned  tlb_victim;
        frame_t       frame_of_page [PAGE_COUNT];
        bit           page_mapped [PAGE_COUNT];
        int unsigned  next_frame;
        xlat_result_t expected_q[$];
        int unsigned  mismatches;

        function void note_request(logic [VA_W-1:0] va);
            page_t        page;
            offset_t      offset;
            frame_t       frame;
            xlat_result_t res;
            page   = page_t'(va >> OFFSET_W);
            offset = offset_t'(va);
            frame  = '0;
            res    = '0;
            for (int i = 0; i < tlb_used; i++) begin
                if (tlb_tag[i] == page) begin
                    frame   = tlb_frame[i];
                    res.hit = 1'b1;
                    break;
                end
            end
            if (!res.hit) begin
                if (!page_mapped[page]) begin
                    res.fault           = 1'b1;
                    frame_of_page[page] = frame_t'(next_frame % PAGE_COUNT);
                    page_mapped[page]   = 1'b1;
                    if (next_frame < PAGE_COUNT)
                        next_frame++;
                end
                frame = frame_of_page[page];
                // fill empty slots first, then replace oldest entry
                if (tlb_used < TLB_ENTRIES) begin
                    tlb_tag[tlb_used]   = page;
                    tlb_frame[tlb_used] = frame;
                    tlb_used++;
                end else begin
                    tlb_tag[tlb_victim]   = page;
                    tlb_frame[tlb_victim] = frame;
                    tlb_victim = (tlb_victim + 1) % TLB_ENTRIES;
                end
            end
            res.phys = PA_W'(frame * PAGE_BYTES + offset);
            expected_q.push_back(res);
        endfunction

        task report_mismatch(string what);
            if (mismatches < MAX_PRINTED)
                $display("%0t mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_result(logic [PA_W-1:0] phys, logic hit, logic fault);
            xlat_result_t want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result pa=%h hit=%b fault=%b",
                                          phys, hit, fault));
                return;
            end
            want = expected_q.pop_front();
            if (phys !== want.phys)
                report_mismatch($sformatf("physical_address %h, want %h", phys, want.phys));
            if (hit !== want.hit)
                report_mismatch($sformatf("tlb_hit %b, want %b (pa %h)", hit, want.hit,
                                          want.phys));
            if (fault !== want.fault)
                report_mismatch($sformatf("page_fault %b, want %b (pa %h)", fault, want.fault,
                                          want.phys));
        endtask
    endclass

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [VA_W-1:0]   s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [PA_W-1:0]   m_tdata;
    logic [1:0]        m_tuser;

    xlat_scoreboard sb = new();
    page_t          recent_pages[$];
    int             idle_cycles = 0;

    tlb_page_table_translator_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Favor recently used pages so that hits, evictions and refills all occur
    function logic [VA_W-1:0] next_random_va();
        int    r;
        page_t page;
        r = $urandom_range(0, 99);
        if (r < 50 && recent_pages.size() > 0)
            page = recent_pages[$urandom_range(0, recent_pages.size() - 1)];
        else if (r < 80)
            page = page_t'($urandom_range(0, 63));
        else
            page = page_t'($urandom_range(0, PAGE_COUNT - 1));
        return {page, offset_t'($urandom)};
    endfunction

    task send_request(input logic [VA_W-1:0] va, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= va;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(va);
        recent_pages.push_back(page_t'(va >> OFFSET_W));
        if (recent_pages.size() > RECENT_DEPTH)
            void'(recent_pages.pop_front());
    endtask

    // Hold off until every outstanding translation has come back
    task drain_requests();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.expected_q.size() != 0);
    endtask

    task run_directed();
        page_t page;
        send_request(16'h0000, 1'b0);
        send_request(16'hFFFF, 1'b0);
        send_request(16'h00AB, 1'b0);
        send_request(16'hFF00, 1'b0);
        // sixteen new pages fill the TLB and push out pages 00 and FF
        for (int p = 1; p <= TLB_ENTRIES; p++) begin
            page = page_t'(p);
            send_request({page, offset_t'(8'h5A ^ page)}, 1'b0);
        end
        send_request(16'h0033, 1'b0);
        send_request(16'hFF80, 1'b0);
        send_request(16'h5555, 1'b0);
        send_request(16'hAAAA, 1'b0);
    endtask

    initial begin
        bit burst;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        run_directed();
        drain_requests();
        burst = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 64 == 0)
                burst = ($urandom_range(0, 3) == 0);
            if (n == RANDOM_ITEMS / 3 || n == 2 * RANDOM_ITEMS / 3)
                drain_requests();
            send_request(next_random_va(), burst);
        end
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Result side backpressure: random stalls with occasional long ready stretches
    initial begin
        int gap;
        int hold;
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
            repeat (hold) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser[0], m_tuser[1]);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/tlbpt_pkg.sv
rtl/tlbpt_ram.sv
rtl/tlbpt_queue.sv
rtl/tlbpt_front.sv
rtl/tlbpt_back.sv
rtl/tlb_page_table_translator_core.sv
bench/tb_tlb_page_table_translator_core.sv
